// ===== hw/rtl/flock_centering_step_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Flock centering step unit: assertion macros
// Concurrent assertion wrappers, empty when building for synthesis.
// ----------------------------------------------------------------------------
`ifndef FLOCK_CENTERING_STEP_UNIT_ASSERT_SVH
`define FLOCK_CENTERING_STEP_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define FCS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("fcs assertion failed");
`define FCS_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("fcs assertion failed");
`else
`define FCS_ASSERT(lbl, clk, rst_n, prop)
`define FCS_ASSERT_NR(lbl, clk, prop)
`endif
`endif

// ===== hw/rtl/fcs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flock centering step package
// Beat types, register map, function codes and controller types.
// ----------------------------------------------------------------------------
package fcs_pkg;

  localparam int DATA_W = 32;
  localparam int DT_W   = 24;
  localparam int Q_FRAC = 16;
  localparam int ADDR_W = 4;

  localparam logic FUNC_FRAME    = 1'b0;
  localparam logic FUNC_PARTICLE = 1'b1;

  localparam logic [1:0] REG_ANCHOR_X = 2'd0;
  localparam logic [1:0] REG_ANCHOR_Y = 2'd1;
  localparam logic [1:0] REG_ANCHOR_Z = 2'd2;

  typedef struct packed {
    logic                     func;
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] pos_z;
    logic signed [DATA_W-1:0] dir_x;
    logic signed [DATA_W-1:0] dir_y;
    logic signed [DATA_W-1:0] dir_z;
    logic        [DT_W-1:0]   time_step;
  } in_beat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] new_dir_x;
    logic signed [DATA_W-1:0] new_dir_y;
    logic signed [DATA_W-1:0] new_dir_z;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_RES,
    ST_DIV,
    ST_DIV_END
  } state_t;

  typedef struct packed {
    logic load_part;
    logic load_frame;
    logic mul_step;
    logic res_load;
    logic div_step;
    logic div_done;
  } fcs_cmd_t;

  typedef struct packed {
    logic cnt_zero;
  } fcs_status_t;

endpackage

// ===== hw/rtl/fcs_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flock centering anchor registers
// APB-style register file holding the anchor position.
// ----------------------------------------------------------------------------
module fcs_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fcs_pkg::ADDR_W-1:0]          paddr,
  input  logic [fcs_pkg::DATA_W-1:0]          pwdata,
  output logic [fcs_pkg::DATA_W-1:0]          prdata,
  output logic                                pready,
  output logic signed [fcs_pkg::DATA_W-1:0]   anchor_x,
  output logic signed [fcs_pkg::DATA_W-1:0]   anchor_y,
  output logic signed [fcs_pkg::DATA_W-1:0]   anchor_z
);

  logic signed [fcs_pkg::DATA_W-1:0] anchor_x_r, anchor_x_nxt;
  logic signed [fcs_pkg::DATA_W-1:0] anchor_y_r, anchor_y_nxt;
  logic signed [fcs_pkg::DATA_W-1:0] anchor_z_r, anchor_z_nxt;
  logic [1:0] idx;
  logic       wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    anchor_x_nxt = anchor_x_r;
    anchor_y_nxt = anchor_y_r;
    anchor_z_nxt = anchor_z_r;
    if (wr_en) begin
      unique case (idx)
        fcs_pkg::REG_ANCHOR_X: anchor_x_nxt = pwdata;
        fcs_pkg::REG_ANCHOR_Y: anchor_y_nxt = pwdata;
        fcs_pkg::REG_ANCHOR_Z: anchor_z_nxt = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      fcs_pkg::REG_ANCHOR_X: prdata = anchor_x_r;
      fcs_pkg::REG_ANCHOR_Y: prdata = anchor_y_r;
      fcs_pkg::REG_ANCHOR_Z: prdata = anchor_z_r;
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      anchor_x_r <= '0;
      anchor_y_r <= '0;
      anchor_z_r <= '0;
    end else begin
      anchor_x_r <= anchor_x_nxt;
      anchor_y_r <= anchor_y_nxt;
      anchor_z_r <= anchor_z_nxt;
    end
  end

  assign anchor_x = anchor_x_r;
  assign anchor_y = anchor_y_r;
  assign anchor_z = anchor_z_r;

endmodule

// ===== hw/rtl/fcs_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flock centering datapath
// Position sums, count, centre, restoring divider and steering arithmetic.
// ----------------------------------------------------------------------------
module fcs_dp #(
  parameter int MAX_PARTICLES = 4096,
  parameter int CNT_W         = 13,
  parameter int SUM_W         = 44
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  fcs_pkg::fcs_cmd_t                  cmd,
  input  fcs_pkg::in_beat_t                  in_data,
  input  logic signed [fcs_pkg::DATA_W-1:0]  anchor_x,
  input  logic signed [fcs_pkg::DATA_W-1:0]  anchor_y,
  input  logic signed [fcs_pkg::DATA_W-1:0]  anchor_z,
  output fcs_pkg::fcs_status_t               status,
  output fcs_pkg::out_beat_t                 out_data
);

  localparam int DW     = fcs_pkg::DATA_W;
  localparam int PROD_W = DW + 1 + fcs_pkg::DT_W + 1;
  localparam int SH_W   = PROD_W - fcs_pkg::Q_FRAC;
  localparam int RES_W  = SH_W + 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PARTICLES);

  logic signed [DW-1:0]    pos_w [3];
  logic signed [DW-1:0]    dir_w [3];
  logic signed [DW-1:0]    anc_w [3];

  logic signed [SUM_W-1:0] sum_r [3];
  logic signed [SUM_W-1:0] sum_nxt [3];
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic signed [DW-1:0]    centre_r [3];
  logic signed [DW-1:0]    centre_nxt [3];
  logic                    take;

  logic signed [DW:0]          diff_r [3];
  logic signed [DW-1:0]        dir_r [3];
  logic [fcs_pkg::DT_W-1:0]    dt_r;
  logic signed [fcs_pkg::DT_W:0] dt_s;
  logic signed [PROD_W-1:0]    mul_w [3];
  logic signed [PROD_W-1:0]    prod_r [3];
  logic signed [SH_W-1:0]      sh_w [3];
  logic signed [RES_W-1:0]     add_w [3];
  logic signed [DW-1:0]        sat_w [3];
  fcs_pkg::out_beat_t          out_r;

  logic [SUM_W-1:0]  quo_r [3];
  logic [CNT_W-1:0]  rem_r [3];
  logic              neg_r [3];
  logic [CNT_W-1:0]  dvs_r;
  logic [CNT_W:0]    trial_w [3];
  logic [CNT_W:0]    tdif_w [3];
  logic              ge_w [3];
  logic [SUM_W-1:0]  mag_w [3];
  logic [DW-1:0]     qlo_w [3];

  assign pos_w[0] = in_data.pos_x;
  assign pos_w[1] = in_data.pos_y;
  assign pos_w[2] = in_data.pos_z;
  assign dir_w[0] = in_data.dir_x;
  assign dir_w[1] = in_data.dir_y;
  assign dir_w[2] = in_data.dir_z;
  assign anc_w[0] = anchor_x;
  assign anc_w[1] = anchor_y;
  assign anc_w[2] = anchor_z;

  assign take            = count_r < CNT_MAX;
  assign status.cnt_zero = (count_r == '0);
  assign dt_s            = $signed({1'b0, dt_r});

  always_comb begin
    count_nxt = count_r;
    if (cmd.load_frame) begin
      count_nxt = '0;
    end else if (cmd.load_part && take) begin
      count_nxt = count_r + CNT_W'(1);
    end
    for (int i = 0; i < 3; i++) begin
      sum_nxt[i]    = sum_r[i];
      centre_nxt[i] = centre_r[i];
      if (cmd.load_frame) begin
        sum_nxt[i] = '0;
        if (status.cnt_zero) begin
          centre_nxt[i] = anc_w[i];
        end
      end else if (cmd.load_part && take) begin
        sum_nxt[i] = sum_r[i] + SUM_W'(pos_w[i]);
      end
      // divider: one quotient bit per step
      trial_w[i] = {rem_r[i], quo_r[i][SUM_W-1]};
      tdif_w[i]  = trial_w[i] - {1'b0, dvs_r};
      ge_w[i]    = trial_w[i] >= {1'b0, dvs_r};
      mag_w[i]   = sum_r[i][SUM_W-1] ? SUM_W'(-sum_r[i]) : SUM_W'(sum_r[i]);
      qlo_w[i]   = quo_r[i][DW-1:0];
      if (cmd.div_done) begin
        centre_nxt[i] = neg_r[i] ? $signed(-qlo_w[i]) : $signed(qlo_w[i]);
      end
      // steering term, floor shift then saturate
      mul_w[i] = diff_r[i] * dt_s;
      sh_w[i]  = prod_r[i][PROD_W-1:fcs_pkg::Q_FRAC];
      add_w[i] = RES_W'(sh_w[i]) + RES_W'(dir_r[i]);
      if (add_w[i][RES_W-1:DW-1] == '0 || add_w[i][RES_W-1:DW-1] == '1) begin
        sat_w[i] = add_w[i][DW-1:0];
      end else if (add_w[i][RES_W-1]) begin
        sat_w[i] = {1'b1, {(DW-1){1'b0}}};
      end else begin
        sat_w[i] = {1'b0, {(DW-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      for (int i = 0; i < 3; i++) begin
        sum_r[i]    <= '0;
        centre_r[i] <= '0;
      end
    end else begin
      count_r <= count_nxt;
      for (int i = 0; i < 3; i++) begin
        sum_r[i]    <= sum_nxt[i];
        centre_r[i] <= centre_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_part) begin
      dt_r <= in_data.time_step;
    end
    if (cmd.load_frame) begin
      dvs_r <= count_r;
    end
    for (int i = 0; i < 3; i++) begin
      if (cmd.load_part) begin
        diff_r[i] <= (DW+1)'(centre_r[i]) - (DW+1)'(pos_w[i]);
        dir_r[i]  <= dir_w[i];
      end
      if (cmd.mul_step) begin
        prod_r[i] <= mul_w[i];
      end
      if (cmd.load_frame) begin
        neg_r[i] <= sum_r[i][SUM_W-1];
        quo_r[i] <= mag_w[i];
        rem_r[i] <= '0;
      end else if (cmd.div_step) begin
        quo_r[i] <= {quo_r[i][SUM_W-2:0], ge_w[i]};
        rem_r[i] <= ge_w[i] ? tdif_w[i][CNT_W-1:0] : trial_w[i][CNT_W-1:0];
      end
    end
    if (cmd.res_load) begin
      out_r.new_dir_x <= sat_w[0];
      out_r.new_dir_y <= sat_w[1];
      out_r.new_dir_z <= sat_w[2];
    end
  end

  assign out_data = out_r;

endmodule

// ===== hw/rtl/fcs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flock centering controller
// Sequences particle and frame-start beats and owns the result valid.
// ----------------------------------------------------------------------------
`include "flock_centering_step_unit_assert.svh"

module fcs_ctrl #(
  parameter int SUM_W = 44
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_func,
  input  logic                  out_stall,
  input  fcs_pkg::fcs_status_t  status,
  output logic                  in_stall,
  output logic                  out_valid,
  output fcs_pkg::fcs_cmd_t     cmd
);

  localparam int DIV_CW = $clog2(SUM_W);
  localparam logic [DIV_CW-1:0] DIV_LAST = DIV_CW'(SUM_W - 1);

  fcs_pkg::state_t    state_r, state_nxt;
  logic [DIV_CW-1:0]  div_cnt_r, div_cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               slot_free;

  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt   = state_r;
    div_cnt_nxt = div_cnt_r;
    unique case (state_r)
      fcs_pkg::ST_IDLE: begin
        div_cnt_nxt = DIV_LAST;
        if (in_valid) begin
          if (in_func == fcs_pkg::FUNC_PARTICLE) begin
            state_nxt = fcs_pkg::ST_MUL;
          end else if (!status.cnt_zero) begin
            state_nxt = fcs_pkg::ST_DIV;
          end
        end
      end
      fcs_pkg::ST_MUL: state_nxt = fcs_pkg::ST_RES;
      fcs_pkg::ST_RES: begin
        if (slot_free) begin
          state_nxt = fcs_pkg::ST_IDLE;
        end
      end
      fcs_pkg::ST_DIV: begin
        div_cnt_nxt = div_cnt_r - DIV_CW'(1);
        if (div_cnt_r == '0) begin
          state_nxt = fcs_pkg::ST_DIV_END;
        end
      end
      fcs_pkg::ST_DIV_END: state_nxt = fcs_pkg::ST_IDLE;
      default:             state_nxt = fcs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      fcs_pkg::ST_IDLE: begin
        in_stall       = 1'b0;
        cmd.load_part  = in_valid && (in_func == fcs_pkg::FUNC_PARTICLE);
        cmd.load_frame = in_valid && (in_func == fcs_pkg::FUNC_FRAME);
      end
      fcs_pkg::ST_MUL:     cmd.mul_step = 1'b1;
      fcs_pkg::ST_RES:     cmd.res_load = slot_free;
      fcs_pkg::ST_DIV:     cmd.div_step = 1'b1;
      fcs_pkg::ST_DIV_END: cmd.div_done = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.res_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fcs_pkg::ST_IDLE;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `FCS_ASSERT(a_no_overwrite, clk, rst_n, cmd.res_load |-> (!out_valid_r || !out_stall))
  `FCS_ASSERT(a_one_cmd, clk, rst_n, $onehot0({cmd.load_part, cmd.load_frame, cmd.mul_step, cmd.res_load, cmd.div_step, cmd.div_done}))
  `FCS_ASSERT(a_frame_div, clk, rst_n, (state_r == fcs_pkg::ST_IDLE && in_valid && in_func == fcs_pkg::FUNC_FRAME && !status.cnt_zero) |=> (state_r == fcs_pkg::ST_DIV))
  `FCS_ASSERT_NR(a_reset_idle, clk, !rst_n |=> (state_r == fcs_pkg::ST_IDLE && !out_valid_r))

endmodule

// ===== hw/rtl/flock_centering_step_unit.sv =====
`timescale 1ns / 1ps
// Particle beat: difference registered on acceptance, then multiply in ST_MUL and
//   add and valid in ST_RES once the output register is free; next beat taken in idle.
// Frame-start beat: an empty frame loads the anchors as centre, else the restoring
//   divider, one quotient bit per cycle, runs through ST_DIV and ST_DIV_END.
// Synchronous active-low reset clears sums, count, centre, anchors and valid.
// ----------------------------------------------------------------------------
// Flock centering step unit
// Cohesion rule: frame-start beats update the flock centre, particle beats
// steer their direction toward it.
// ----------------------------------------------------------------------------
module flock_centering_step_unit #(
  parameter int MAX_PARTICLES = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  fcs_pkg::in_beat_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output fcs_pkg::out_beat_t                  out_data,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fcs_pkg::ADDR_W-1:0]          paddr,
  input  logic [fcs_pkg::DATA_W-1:0]          pwdata,
  output logic [fcs_pkg::DATA_W-1:0]          prdata,
  output logic                                pready
);

  localparam int CNT_W = $clog2(MAX_PARTICLES + 1);
  localparam int SUM_W = fcs_pkg::DATA_W + $clog2(MAX_PARTICLES);

  logic signed [fcs_pkg::DATA_W-1:0] anchor_x;
  logic signed [fcs_pkg::DATA_W-1:0] anchor_y;
  logic signed [fcs_pkg::DATA_W-1:0] anchor_z;
  fcs_pkg::fcs_cmd_t                 cmd;
  fcs_pkg::fcs_status_t              status;

  fcs_regs u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .anchor_x (anchor_x),
    .anchor_y (anchor_y),
    .anchor_z (anchor_z)
  );

  fcs_ctrl #(
    .SUM_W (SUM_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_func   (in_data.func),
    .out_stall (out_stall),
    .status    (status),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  fcs_dp #(
    .MAX_PARTICLES (MAX_PARTICLES),
    .CNT_W         (CNT_W),
    .SUM_W         (SUM_W)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .anchor_x (anchor_x),
    .anchor_y (anchor_y),
    .anchor_z (anchor_z),
    .status   (status),
    .out_data (out_data)
  );

endmodule

// ===== sim/tb_flock_centering_step_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flock centering step unit testbench
// Drives frame-start and particle beats with random gaps and output stalls.
// Anchor registers are written over the register port. A built-in model of the
// cohesion rule predicts each steered direction, and every result beat is
// compared field by field with the oldest prediction. Covers the empty frame,
// the mean truncating toward zero, a long frame with positions at the coordinate
// extremes and output clamping.
// ----------------------------------------------------------------------------
module tb_flock_centering_step_unit;

  localparam int          MAX_FLOCK     = 4096;
  localparam int          LONG_FRAME    = 300;
  localparam int          RANDOM_ITEMS  = 750;
  localparam int          SETTLE_CYCLES = 64;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          DRAIN_LIMIT   = 20000;
  localparam int          CYCLE_LIMIT   = 2000000;
  localparam logic [1:0]  REG_UNUSED    = 2'd3;
  localparam logic signed [31:0] Q_MIN  = 32'sh8000_0000;
  localparam logic signed [31:0] Q_MAX  = 32'sh7FFF_FFFF;
  localparam logic [23:0] DT_ONE        = 24'h01_0000;
  localparam logic [23:0] DT_MAX        = 24'hFF_FFFF;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  fcs_pkg::in_beat_t          in_data;
  logic                       out_valid;
  logic                       out_stall;
  fcs_pkg::out_beat_t         out_data;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [fcs_pkg::ADDR_W-1:0] paddr;
  logic [fcs_pkg::DATA_W-1:0] pwdata;
  logic [fcs_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  // model state
  logic signed [31:0]    anchor_q [3];
  longint                pos_sum [3];
  longint                centre_q [3];
  int                    flock_count;
  fcs_pkg::out_beat_t    pending_dirs [$];

  int                    errors;
  int                    cycles;
  logic                  gaps_on;
  logic                  stalls_on;
  logic                  hold_active;
  event                  hold_trigger;

  flock_centering_step_unit #(
    .MAX_PARTICLES(MAX_FLOCK)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 19) == 0) begin
      return $urandom_range(20, 60);
    end
    return $urandom_range(1, 3);
  endfunction

  function automatic logic signed [31:0] rand_coord(input logic signed [31:0] base);
    logic [31:0] off;
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) begin
      off = $urandom_range(0, 262143) - 131072;
      return base + off;
    end
    if (sel < 9) begin
      return $urandom;
    end
    case ($urandom_range(0, 3))
      0:       return Q_MIN;
      1:       return Q_MAX;
      2:       return 32'sd0;
      default: return -32'sd1;
    endcase
  endfunction

  function automatic logic [23:0] rand_dt();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) begin
      return 24'($urandom_range(0, 131072));
    end
    if (sel < 8) begin
      return 24'($urandom);
    end
    return (sel == 8) ? 24'd0 : DT_MAX;
  endfunction

  function automatic fcs_pkg::in_beat_t particle(input logic signed [31:0] px, py, pz,
                                                 dx, dy, dz,
                                                 input logic [23:0] dt);
    fcs_pkg::in_beat_t b;
    b.func      = fcs_pkg::FUNC_PARTICLE;
    b.pos_x     = px;
    b.pos_y     = py;
    b.pos_z     = pz;
    b.dir_x     = dx;
    b.dir_y     = dy;
    b.dir_z     = dz;
    b.time_step = dt;
    return b;
  endfunction

  // ignored fields carry junk
  function automatic fcs_pkg::in_beat_t frame_beat();
    fcs_pkg::in_beat_t b;
    b = particle($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 24'($urandom));
    b.func = fcs_pkg::FUNC_FRAME;
    return b;
  endfunction

  task automatic advance_flock(input fcs_pkg::in_beat_t b);
    logic signed [31:0] p [3];
    logic signed [31:0] d [3];
    longint             nd [3];
    fcs_pkg::out_beat_t r;
    p = '{b.pos_x, b.pos_y, b.pos_z};
    d = '{b.dir_x, b.dir_y, b.dir_z};
    if (b.func == fcs_pkg::FUNC_FRAME) begin
      for (int i = 0; i < 3; i++) begin
        centre_q[i] = (flock_count != 0) ? pos_sum[i] / longint'(flock_count)
                                         : longint'(anchor_q[i]);
        pos_sum[i] = 0;
      end
      flock_count = 0;
    end else begin
      for (int i = 0; i < 3; i++) begin
        // arithmetic shift floors the Q32 product back to Q16
        nd[i] = longint'(d[i]) +
                (((centre_q[i] - longint'(p[i])) * longint'(b.time_step)) >>> 16);
        if (nd[i] > longint'(Q_MAX)) begin
          nd[i] = longint'(Q_MAX);
        end else if (nd[i] < longint'(Q_MIN)) begin
          nd[i] = longint'(Q_MIN);
        end
        if (flock_count < MAX_FLOCK) begin
          pos_sum[i] += longint'(p[i]);
        end
      end
      if (flock_count < MAX_FLOCK) begin
        flock_count++;
      end
      r.new_dir_x = nd[0][31:0];
      r.new_dir_y = nd[1][31:0];
      r.new_dir_z = nd[2][31:0];
      pending_dirs.push_back(r);
    end
  endtask

  task automatic send_beat(input fcs_pkg::in_beat_t b);
    int gap;
    gap = (gaps_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall);
    advance_flock(b);
  endtask

  // anchors may only change once the unit has drained, divider included
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_dirs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_access(input logic [1:0] idx, input logic wr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (wr && idx != REG_UNUSED) begin
      anchor_q[idx] = wdata;
    end
    @(posedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    logic [31:0] unused;
    reg_access(idx, 1'b1, val, unused);
  endtask

  task automatic check_anchors();
    logic [31:0] got;
    logic [1:0]  regs [3];
    regs = '{fcs_pkg::REG_ANCHOR_X, fcs_pkg::REG_ANCHOR_Y, fcs_pkg::REG_ANCHOR_Z};
    for (int i = 0; i < 3; i++) begin
      reg_access(regs[i], 1'b0, '0, got);
      if (got !== anchor_q[i]) begin
        $display("%0t: anchor %0d readback expected %h actual %h", $realtime, i,
                 anchor_q[i], got);
        errors++;
      end
    end
  endtask

  task automatic rand_anchors();
    logic [31:0] v;
    logic [1:0]  regs [3];
    regs = '{fcs_pkg::REG_ANCHOR_X, fcs_pkg::REG_ANCHOR_Y, fcs_pkg::REG_ANCHOR_Z};
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(0, 5))
        0:       v = Q_MIN;
        1:       v = Q_MAX;
        2:       v = 32'd0;
        default: v = $urandom;
      endcase
      reg_write(regs[i], v);
    end
  endtask

  // centre starts at zero; saturation both ways, floor rounding, empty frame
  task automatic test_reset_state();
    send_beat(particle(Q_MIN, Q_MAX, 32'sd0, Q_MAX, Q_MIN, -32'sd1, DT_MAX));
    send_beat(particle(32'sd1, -32'sd1, 32'sd12345, Q_MAX, Q_MIN, 32'sd0, 24'd0));
    send_beat(particle(32'sd1, -32'sd1, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 24'd1));
    send_beat(frame_beat());
    send_beat(particle(32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, DT_ONE));
    send_beat(frame_beat());
    send_beat(frame_beat());
    send_beat(particle(32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, DT_ONE));
  endtask

  task automatic test_registers();
    wait_idle();
    reg_write(fcs_pkg::REG_ANCHOR_X, Q_MIN);
    reg_write(fcs_pkg::REG_ANCHOR_Y, Q_MAX);
    reg_write(fcs_pkg::REG_ANCHOR_Z, 32'h1234_5678);
    reg_write(REG_UNUSED, 32'hDEAD_BEEF);
    check_anchors();
    send_beat(frame_beat());
    send_beat(particle(32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, DT_ONE));
    send_beat(particle(Q_MAX, Q_MIN, 32'sd0, 32'sd0, 32'sd0, 32'sd0, DT_MAX));
    wait_idle();
    reg_write(fcs_pkg::REG_ANCHOR_X, -32'sd1);
    reg_write(fcs_pkg::REG_ANCHOR_Y, 32'sd1);
    reg_write(fcs_pkg::REG_ANCHOR_Z, Q_MIN);
    check_anchors();
  endtask

  // negative means truncate toward zero
  task automatic test_mean_truncation();
    send_beat(frame_beat());
    send_beat(particle(32'sd3, 32'sd7, -32'sd5, 32'sd0, 32'sd0, 32'sd0, DT_ONE));
    send_beat(particle(-32'sd10, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, DT_ONE));
    send_beat(frame_beat());
    send_beat(particle(32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, DT_ONE));
  endtask

  // long frame with the x and y positions at the coordinate extremes
  task automatic test_large_frame();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    send_beat(frame_beat());
    for (int i = 0; i < LONG_FRAME; i++) begin
      send_beat(particle(Q_MIN, Q_MAX, $urandom, rand_coord(0), rand_coord(0),
                         rand_coord(0), rand_dt()));
    end
    send_beat(frame_beat());
    send_beat(particle(32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, DT_ONE));
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  task automatic test_backpressure();
    wait_idle();
    gaps_on = 1'b0;
    -> hold_trigger;
    for (int i = 0; i < 30; i++) begin
      if (i == 12) begin
        send_beat(frame_beat());
      end
      send_beat(particle(rand_coord(0), rand_coord(0), rand_coord(0), rand_coord(0),
                         rand_coord(0), rand_coord(0), rand_dt()));
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_random();
    int                 sent;
    int                 n;
    logic signed [31:0] base [3];
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 1) == 0) begin
        wait_idle();
        rand_anchors();
      end
      gaps_on   = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(1, 4)) begin
        send_beat(frame_beat());
        for (int i = 0; i < 3; i++) begin
          base[i] = $urandom;
          base[i] = base[i] >>> $urandom_range(0, 20);
        end
        n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
        for (int k = 0; k < n; k++) begin
          send_beat(particle(rand_coord(base[0]), rand_coord(base[1]), rand_coord(base[2]),
                             rand_coord(0), rand_coord(0), rand_coord(0), rand_dt()));
        end
        sent += n + 1;
      end
    end
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  initial begin
    hold_active = 1'b0;
    forever begin
      @(hold_trigger);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_active <= 1'b0;
    end
  end

  initial begin
    int run;
    run       = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (run > 0) begin
        run--;
      end else if (stalls_on && $urandom_range(0, 3) == 0) begin
        run = pick_gap();
      end
      out_stall <= hold_active || (run > 0);
    end
  end

  always @(posedge clk) begin : check_results
    fcs_pkg::out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_dirs.size() == 0) begin
        $display("%0t: unexpected result beat, expected none actual %h", $realtime,
                 out_data);
        errors++;
      end else begin
        want = pending_dirs.pop_front();
        if (out_data.new_dir_x !== want.new_dir_x) begin
          $display("%0t: new_dir_x expected %h actual %h", $realtime, want.new_dir_x,
                   out_data.new_dir_x);
          errors++;
        end
        if (out_data.new_dir_y !== want.new_dir_y) begin
          $display("%0t: new_dir_y expected %h actual %h", $realtime, want.new_dir_y,
                   out_data.new_dir_y);
          errors++;
        end
        if (out_data.new_dir_z !== want.new_dir_z) begin
          $display("%0t: new_dir_z expected %h actual %h", $realtime, want.new_dir_z,
                   out_data.new_dir_z);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $realtime, cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    errors      = 0;
    cycles      = 0;
    gaps_on     = 1'b1;
    stalls_on   = 1'b1;
    flock_count = 0;
    for (int i = 0; i < 3; i++) begin
      anchor_q[i] = '0;
      pos_sum[i]  = 0;
      centre_q[i] = 0;
    end
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_registers();
    test_mean_truncation();
    test_large_frame();
    test_backpressure();
    test_random();

    in_valid <= 1'b0;
    for (int k = 0; k < DRAIN_LIMIT && pending_dirs.size() != 0; k++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_dirs.size() != 0) begin
      $display("%0t: %0d result beats never arrived, next expected %h", $realtime,
               pending_dirs.size(), pending_dirs[0]);
      errors++;
    end
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
